### rtl/core/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Holds operation and status codes, controller states and the
// command/status structs that join the controller and the datapath.
package rau_pkg;

   localparam int CMD_W      = 3;
   localparam int NUM_W      = 32;
   localparam int DEN_W      = 31;
   localparam int ORD_W      = 2;
   localparam int STS_W      = 2;
   localparam int RSP_DATA_W = 72;

   localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_INVALID  = 2'd1;
   localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd2;

   localparam logic signed [ORD_W-1:0] ORD_LESS    = 2'b11;
   localparam logic signed [ORD_W-1:0] ORD_EQUAL   = 2'b00;
   localparam logic signed [ORD_W-1:0] ORD_GREATER = 2'b01;

   localparam logic [63:0] NUM_LIMIT_POS = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] NUM_LIMIT_NEG = 64'h0000_0000_8000_0000;
   localparam logic [63:0] DEN_LIMIT     = 64'h0000_0000_7FFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_D,
      ST_COMBINE,
      ST_CHECK,
      ST_GCD,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MS_NONE,
      MS_X,
      MS_Y,
      MS_D
   } mul_step_type;

   typedef struct packed {
      logic         load;
      mul_step_type mul_step;
      logic         combine;
      logic         gcd_init;
      logic         gcd_step;
      logic         div_init;
      logic         div_step;
      logic         out_write;
   } dp_cmd_type;

   typedef struct packed {
      logic quick;
      logic gcd_done;
      logic div_last;
      logic out_free;
   } dp_sts_type;

endpackage

### rtl/core/rau_ctrl.sv
// Sequencer for the rational arithmetic unit.
// Steps the datapath through multiply, combine, GCD and divide phases.
// Depends on rau_pkg.
module rau_ctrl
   import rau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       idle
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X:   state_in = ST_MUL_Y;
         ST_MUL_Y:   state_in = ST_MUL_D;
         ST_MUL_D:   state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = sts.quick ? ST_FINISH : ST_GCD;
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      idle = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle     = 1'b1;
            cmd.load = req_fire;
         end
         ST_MUL_X:   cmd.mul_step = MS_X;
         ST_MUL_Y:   cmd.mul_step = MS_Y;
         ST_MUL_D:   cmd.mul_step = MS_D;
         ST_COMBINE: cmd.combine  = 1'b1;
         ST_CHECK: begin
            cmd.gcd_init = !sts.quick;
         end
         ST_GCD: begin
            cmd.gcd_step = !sts.gcd_done;
            cmd.div_init = sts.gcd_done;
         end
         ST_DIV:    cmd.div_step  = 1'b1;
         ST_FINISH: cmd.out_write = sts.out_free;
         default: begin
            cmd  = '0;
            idle = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand registers, shared
// multiplier, sign-magnitude combine, binary GCD, two-lane restoring
// divider and the result register. Depends on rau_pkg.
module rau_datapath
   import rau_pkg::*;
#(
   parameter int W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic [CMD_W-1:0]         in_cmd,
   input  logic signed [W-1:0]      in_left_num,
   input  logic signed [W-1:0]      in_left_den,
   input  logic signed [W-1:0]      in_right_num,
   input  logic signed [W-1:0]      in_right_den,
   input  logic                     out_ready,
   output logic                     out_valid,
   output logic signed [NUM_W-1:0]  out_num,
   output logic [DEN_W-1:0]         out_den,
   output logic signed [ORD_W-1:0]  out_order,
   output logic [STS_W-1:0]         out_status
);

   localparam int PW = 2 * W;
   localparam int KW = $clog2(PW + 1);
   localparam int CW = $clog2(PW);

   function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   // operand registers
   logic [CMD_W-1:0]    op_ff;
   logic signed [W-1:0] ln_ff, ld_ff, rn_ff, rd_ff;
   // products, combined numerator, denominator
   logic [PW-1:0]       p0_ff, p1_ff, nm_ff, dm_ff;
   logic                neg_ff;
   // GCD state; a_ff later holds the divisor
   logic [PW-1:0]       a_ff, b_ff;
   logic [KW-1:0]       k_ff;
   // divider remainders and step count
   logic [PW-1:0]       remn_ff, remd_ff;
   logic [CW-1:0]       cnt_ff;
   // result register
   logic                     out_valid_ff;
   logic signed [NUM_W-1:0]  out_num_ff;
   logic [DEN_W-1:0]         out_den_ff;
   logic signed [ORD_W-1:0]  out_order_ff;
   logic [STS_W-1:0]         out_status_ff;

   logic [W-1:0]  ml, mdl, mr, mdr;
   logic          sl, sr, sb;
   logic [W-1:0]  op_a, op_b;
   logic [PW-1:0] prod;
   logic [PW-1:0] sum;
   logic [PW:0]   diff;
   logic [PW-1:0] rdiff;
   logic [PW-1:0] nm_in;
   logic          neg_in;
   logic          err;
   logic [PW:0]   gdiff;
   logic [PW-1:0] gbdiff;
   logic [PW:0]   remn_sh, remd_sh, trial_n, trial_d;
   logic          ovf;
   logic [63:0]   nm_ext, num_signed;
   logic                     out_valid_in;
   logic signed [NUM_W-1:0]  res_num;
   logic [DEN_W-1:0]         res_den;
   logic signed [ORD_W-1:0]  res_order;
   logic [STS_W-1:0]         res_status;

   assign ml  = mag_of(ln_ff);
   assign mdl = mag_of(ld_ff);
   assign mr  = mag_of(rn_ff);
   assign mdr = mag_of(rd_ff);

   // numerator signs after moving the denominator sign across
   assign sl = (ln_ff != '0) && (ln_ff[W-1] ^ ld_ff[W-1]);
   assign sr = (rn_ff != '0) && (rn_ff[W-1] ^ rd_ff[W-1]);
   assign sb = (op_ff == CMD_SUB || op_ff == CMD_CMP) ? !sr : sr;

   assign err = (op_ff > CMD_CMP) || (ld_ff == '0) || (rd_ff == '0)
                || (op_ff == CMD_DIV && rn_ff == '0);

   // shared multiplier operand select
   always_comb begin
      op_a = ml;
      op_b = mdr;
      case (cmd.mul_step)
         MS_X: begin
            op_a = ml;
            op_b = (op_ff == CMD_MUL) ? mr : mdr;
         end
         MS_Y: begin
            op_a = mr;
            op_b = mdl;
         end
         MS_D: begin
            op_a = mdl;
            op_b = (op_ff == CMD_DIV) ? mr : mdr;
         end
         default: begin
            op_a = ml;
            op_b = mdr;
         end
      endcase
   end

   assign prod = PW'(op_a) * PW'(op_b);

   // sign-magnitude add of the two cross products
   assign sum   = p0_ff + p1_ff;
   assign diff  = {1'b0, p0_ff} - {1'b0, p1_ff};
   assign rdiff = p1_ff - p0_ff;

   always_comb begin
      if (op_ff == CMD_MUL || op_ff == CMD_DIV) begin
         nm_in  = p0_ff;
         neg_in = sl ^ sr;
      end else if (sl == sb) begin
         nm_in  = sum;
         neg_in = sl;
      end else if (!diff[PW]) begin
         nm_in  = diff[PW-1:0];
         neg_in = sl;
      end else begin
         nm_in  = rdiff;
         neg_in = sb;
      end
   end

   assign gdiff  = {1'b0, a_ff} - {1'b0, b_ff};
   assign gbdiff = b_ff - a_ff;

   assign remn_sh = {remn_ff, nm_ff[PW-1]};
   assign remd_sh = {remd_ff, dm_ff[PW-1]};
   assign trial_n = remn_sh - {1'b0, a_ff};
   assign trial_d = remd_sh - {1'b0, a_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_cmd;
         ln_ff <= in_left_num;
         ld_ff <= in_left_den;
         rn_ff <= in_right_num;
         rd_ff <= in_right_den;
      end
      case (cmd.mul_step)
         MS_X:    p0_ff <= prod;
         MS_Y:    p1_ff <= prod;
         MS_D:    dm_ff <= prod;
         default: p0_ff <= p0_ff;
      endcase
      if (cmd.combine) begin
         nm_ff  <= nm_in;
         neg_ff <= neg_in;
      end
      if (cmd.gcd_init) begin
         a_ff <= nm_ff;
         b_ff <= dm_ff;
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_ff <= a_ff >> 1;
            b_ff <= b_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_ff <= a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_ff <= b_ff >> 1;
         end else if (!gdiff[PW]) begin
            a_ff <= gdiff[PW-1:0] >> 1;
         end else begin
            b_ff <= gbdiff >> 1;
         end
      end else if (cmd.div_init) begin
         // restore the common power of two: a_ff becomes the GCD
         a_ff    <= a_ff << k_ff;
         remn_ff <= '0;
         remd_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         if (!trial_n[PW]) begin
            remn_ff <= trial_n[PW-1:0];
            nm_ff   <= {nm_ff[PW-2:0], 1'b1};
         end else begin
            remn_ff <= remn_sh[PW-1:0];
            nm_ff   <= {nm_ff[PW-2:0], 1'b0};
         end
         if (!trial_d[PW]) begin
            remd_ff <= trial_d[PW-1:0];
            dm_ff   <= {dm_ff[PW-2:0], 1'b1};
         end else begin
            remd_ff <= remd_sh[PW-1:0];
            dm_ff   <= {dm_ff[PW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // result formatting
   assign nm_ext     = 64'(nm_ff);
   assign num_signed = neg_ff ? (64'd0 - nm_ext) : nm_ext;
   assign ovf = (64'(dm_ff) > DEN_LIMIT)
                || (neg_ff ? (nm_ext > NUM_LIMIT_NEG) : (nm_ext > NUM_LIMIT_POS));

   always_comb begin
      res_num    = '0;
      res_den    = '0;
      res_order  = ORD_EQUAL;
      res_status = STS_OK;
      if (err) begin
         res_status = STS_INVALID;
      end else if (op_ff == CMD_CMP) begin
         if (nm_ff == '0) begin
            res_order = ORD_EQUAL;
         end else begin
            res_order = neg_ff ? ORD_LESS : ORD_GREATER;
         end
      end else if (nm_ff == '0) begin
         res_den = DEN_W'(1);
      end else if (ovf) begin
         res_status = STS_OVERFLOW;
      end else begin
         res_num = num_signed[NUM_W-1:0];
         res_den = DEN_W'(dm_ff);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_write) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_write) begin
         out_num_ff    <= res_num;
         out_den_ff    <= res_den;
         out_order_ff  <= res_order;
         out_status_ff <= res_status;
      end
   end

   assign sts.quick    = err || (op_ff == CMD_CMP) || (nm_ff == '0);
   assign sts.gcd_done = (a_ff == b_ff);
   assign sts.div_last = (cnt_ff == CW'(PW - 1));
   assign sts.out_free = !out_valid_ff || out_ready;

   assign out_valid  = out_valid_ff;
   assign out_num    = out_num_ff;
   assign out_den    = out_den_ff;
   assign out_order  = out_order_ff;
   assign out_status = out_status_ff;

endmodule

### rtl/core/rational_arith_unit_core.sv
// An item passes through the multiply, combine and check states, the binary GCD loop
// and the bit-serial divider, then the finish state writes the output register; errors,
// compares and zero results skip the GCD and divide. Throughput: one item at a time;
// the next transfer is taken once the result sits in the output register, but a result
// that finds it still full holds the sequencer, which stalls the input side.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module rational_arith_unit_core
   import rau_pkg::*;
#(
   parameter int WIDTH = 16,
   localparam int REQ_DATA_W = ((4 * WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [left_num, left_den, right_num, right_den], WIDTH bits each, lowest first
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [cmd]
   input  logic [CMD_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [result_num 32, result_den 31, order 2], then zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // [status]
   output logic [STS_W-1:0]       rsp_tuser
);

   logic                     req_fire;
   logic                     idle;
   dp_cmd_type               dp_cmd;
   dp_sts_type               dp_sts;
   logic signed [NUM_W-1:0]  res_num;
   logic [DEN_W-1:0]         res_den;
   logic signed [ORD_W-1:0]  res_order;

   // take a new item only while the sequencer is idle
   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;

   rau_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .sts      (dp_sts),
      .cmd      (dp_cmd),
      .idle     (idle)
   );

   // unpack the four fraction fields from the request beat
   rau_datapath #(
      .W (WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .sts          (dp_sts),
      .in_cmd       (req_tuser),
      .in_left_num  (req_tdata[WIDTH-1:0]),
      .in_left_den  (req_tdata[2*WIDTH-1:WIDTH]),
      .in_right_num (req_tdata[3*WIDTH-1:2*WIDTH]),
      .in_right_den (req_tdata[4*WIDTH-1:3*WIDTH]),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_num      (res_num),
      .out_den      (res_den),
      .out_order    (res_order),
      .out_status   (rsp_tuser)
   );

   // pack the result fields, zero fill to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W - NUM_W - DEN_W - ORD_W){1'b0}},
                       res_order, res_den, res_num};

`ifndef SYNTH
   // an accepted item keeps the input side closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again right after a transfer");

   // a fresh result is only written while the sequencer is busy
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without an item in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STS_OK || rsp_tuser == STS_INVALID
                      || rsp_tuser == STS_OVERFLOW))
      else $error("undefined status code");

   // error results carry all-zero data
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STS_OK) |-> (rsp_tdata == '0))
      else $error("error result with nonzero data");
`endif

endmodule
